@@ rtl/core/mrfc_pkg.sv @@
// types and constants for the meter response frame checker
package mrfc_pkg;

	localparam logic [7:0] START_BYTE = 8'h68;
	localparam logic [7:0] CTRL_A     = 8'h91;
	localparam logic [7:0] CTRL_B     = 8'hB1;
	localparam logic [7:0] DATA_BIAS  = 8'h33;

	// frame offsets
	localparam int unsigned OFS_START0  = 0;
	localparam int unsigned OFS_START1  = 7;
	localparam int unsigned OFS_CONTROL = 8;
	localparam int unsigned OFS_LENGTH  = 9;
	localparam int unsigned OFS_DATA    = 10;
	localparam int unsigned OFS_VALUE0  = 12;
	localparam int unsigned MIN_FRAME   = 12;

	localparam logic [7:0] LEN_SHORT = 8'd4;
	localparam logic [7:0] LEN_LONG  = 8'd5;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_HEADER      = 3'd1,
		ST_CONTROL     = 3'd2,
		ST_LENGTH      = 3'd3,
		ST_CHECKSUM    = 3'd4,
		ST_UNSUPPORTED = 3'd5
	} status_t;

endpackage

@@ rtl/core/mrfc_in_if.sv @@
// byte channel into the frame checker
interface mrfc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       last_byte;

	modport source (output valid, output rx_byte, output last_byte, input ready);
	modport sink (input valid, input rx_byte, input last_byte, output ready);
endinterface

@@ rtl/core/mrfc_out_if.sv @@
// result channel out of the frame checker
interface mrfc_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [23:0] value_tenths;

	modport source (output valid, output status, output value_tenths, input ready);
	modport sink (input valid, input status, input value_tenths, output ready);
endinterface

@@ rtl/core/meter_response_frame_checker.sv @@
// meter response frame checker: byte-wise header, control, length and checksum check with value decode
// result timing: the result is registered and appears in the cycle after the beat that carries last_byte
// throughput: one byte per cycle; while a result waits, rx.ready follows result.ready, so a
//   byte is taken only in a cycle where the waiting result is taken too
// reset (arst_n low) clears the byte counter, the frame checks and the result valid flag
module meter_response_frame_checker
	import mrfc_pkg::*;
#(
	parameter int unsigned MAX_BUFFER_BYTES = 1023
) (
	input  logic          clk,
	input  logic          arst_n,
	mrfc_in_if.sink       rx,
	mrfc_out_if.source    result
);

	localparam int unsigned CW = $clog2(MAX_BUFFER_BYTES + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BUFFER_BYTES);

	logic [CW-1:0] byte_count_q, byte_count_d, pos;
	logic          header_ok_q, header_ok_d;
	logic          control_ok_q, control_ok_d;
	logic [7:0]    field_length_q, field_length_d;
	logic [7:0]    running_sum_q, running_sum_d;
	logic          sum_matches_q, sum_matches_d;
	logic [7:0]    value_bytes_q [3];
	logic [7:0]    value_bytes_d [3];
	logic [CW-1:0] data_end;
	logic [CW-1:0] frame_min;
	logic          rx_beat;
	logic          out_valid_q;
	status_t       status_q, status_d;
	logic [23:0]   value_q, value_d;

	assign rx.ready = !out_valid_q || result.ready;
	assign rx_beat  = rx.valid && rx.ready;
	assign pos      = byte_count_q;

	// checksum covers bytes up to 9+length, checksum byte at 10+length
	assign data_end  = CW'(OFS_DATA) + CW'(field_length_q);
	assign frame_min = CW'(11) + CW'(field_length_d);

	always_comb begin
		header_ok_d    = header_ok_q;
		control_ok_d   = control_ok_q;
		field_length_d = field_length_q;
		running_sum_d  = running_sum_q;
		sum_matches_d  = sum_matches_q;
		value_bytes_d  = value_bytes_q;
		if (pos == CW'(OFS_START0) || pos == CW'(OFS_START1)) begin
			if (rx.rx_byte != START_BYTE) header_ok_d = 1'b0;
		end
		if (pos == CW'(OFS_CONTROL)) begin
			control_ok_d = (rx.rx_byte == CTRL_A) || (rx.rx_byte == CTRL_B);
		end
		if (pos == CW'(OFS_LENGTH)) begin
			field_length_d = rx.rx_byte;
		end
		if (pos < CW'(OFS_DATA) || pos < data_end) begin
			running_sum_d = running_sum_q + rx.rx_byte;
		end else if (pos == data_end) begin
			sum_matches_d = (running_sum_q == rx.rx_byte);
		end
		for (int i = 0; i < 3; i++) begin
			if (pos == CW'(OFS_VALUE0 + i)) value_bytes_d[i] = rx.rx_byte - DATA_BIAS;
		end
		byte_count_d = (byte_count_q < CNT_MAX) ? byte_count_q + 1'b1 : byte_count_q;

		// checks in priority order, evaluated on the updated frame state
		value_d = '0;
		priority if (byte_count_d < CW'(MIN_FRAME) || !header_ok_d) begin
			status_d = ST_HEADER;
		end else if (!control_ok_d) begin
			status_d = ST_CONTROL;
		end else if (field_length_d < LEN_SHORT || byte_count_d < frame_min) begin
			status_d = ST_LENGTH;
		end else if (!sum_matches_d) begin
			status_d = ST_CHECKSUM;
		end else if (field_length_d == LEN_SHORT) begin
			status_d = ST_OK;
			value_d  = {8'd0, value_bytes_d[0], value_bytes_d[1]};
		end else if (field_length_d == LEN_LONG) begin
			status_d = ST_OK;
			value_d  = {value_bytes_d[2], value_bytes_d[1], value_bytes_d[0]};
		end else begin
			status_d = ST_UNSUPPORTED;
		end
	end

	// frame state, cleared after the last beat of each buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= '0;
			header_ok_q    <= 1'b1;
			control_ok_q   <= 1'b0;
			field_length_q <= '0;
			running_sum_q  <= '0;
			sum_matches_q  <= 1'b0;
			for (int i = 0; i < 3; i++) value_bytes_q[i] <= '0;
		end else if (rx_beat) begin
			if (rx.last_byte) begin
				byte_count_q   <= '0;
				header_ok_q    <= 1'b1;
				control_ok_q   <= 1'b0;
				field_length_q <= '0;
				running_sum_q  <= '0;
				sum_matches_q  <= 1'b0;
				for (int i = 0; i < 3; i++) value_bytes_q[i] <= '0;
			end else begin
				byte_count_q   <= byte_count_d;
				header_ok_q    <= header_ok_d;
				control_ok_q   <= control_ok_d;
				field_length_q <= field_length_d;
				running_sum_q  <= running_sum_d;
				sum_matches_q  <= sum_matches_d;
				value_bytes_q  <= value_bytes_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rx_beat && rx.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_beat && rx.last_byte) begin
			status_q <= status_d;
			value_q  <= value_d;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.status       = status_q;
	assign result.value_tenths = value_q;

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		rx_beat && rx.last_byte |=> out_valid_q)
		else $error("no result after last beat");

	a_last_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		rx_beat && rx.last_byte |=> byte_count_q == '0 && running_sum_q == '0)
		else $error("frame state not cleared after last beat");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= CNT_MAX)
		else $error("byte counter beyond saturation");

	a_error_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_OK |-> value_q == '0)
		else $error("nonzero value with error status");

endmodule
